>>> rtl/lpfc_pkg.sv
// lpfc_pkg: shared constants, codes and types for the permutation stepper
// no dependencies; imported by lpfc_cell and lex_permutation_fixed_point_counter
`timescale 1ns / 1ps
`default_nettype none

package lpfc_pkg;

  // number of cells in the row
  localparam int MAX_ITEMS = 8;

  // fixed field widths
  localparam int VAL_W   = 3;   // one element, value minus one
  localparam int IDX_W   = 3;   // position of a cell
  localparam int CNT_W   = 4;   // item_count register
  localparam int PERM_W  = 24;  // packed permutation word
  localparam int MATCH_W = 16;  // running match count
  localparam int PH_W    = 3;   // sort phase counter

  // last odd-even sort phase, two less than the row length (MAX_ITEMS - 1 phases)
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(MAX_ITEMS - 2);
  localparam logic [CNT_W-1:0] N_MAX  = CNT_W'(MAX_ITEMS);

  // command to every cell of the row
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SWAP,
    OP_SORT
  } cell_op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_SUCC,
    ST_SWAP,
    ST_SORT,
    ST_FINISH
  } state_e;

  // broadcast from the sequencer to the cells
  typedef struct packed {
    cell_op_e         op;
    logic             par;       // sort phase parity
    logic [CNT_W-1:0] n;         // active length
    logic [IDX_W-1:0] piv;       // pivot position
    logic [IDX_W-1:0] succ;      // successor position
    logic [VAL_W-1:0] piv_val;   // element at pivot
    logic [VAL_W-1:0] succ_val;  // element at successor
  } cell_cmd_t;

  // local status of one cell
  typedef struct packed {
    logic rise;  // own element below right neighbor, both active
    logic gt;    // right of pivot, active, greater than pivot element
    logic fix;   // active and holding its own position
  } cell_flag_t;

endpackage : lpfc_pkg

`default_nettype wire

>>> rtl/lex_permutation_fixed_point_counter.sv
// lex_permutation_fixed_point_counter: next lexicographic permutation stepper
// with fixed-point counter; sequencer over a row of lpfc_cell, uses lpfc_pkg
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid_i, in_stall_o, restart_i        | in
//  output  | out_valid_o, out_stall_i, permutation_o, | out
//          | has_fixed_point_o, match_count_o,        |
//          | exhausted_o                              |
//  config  | cfg_valid_i, cfg_ready_o, cfg_data_i     | in
//
// An advance word goes through accept, pivot search, successor search, swap,
// MAX_ITEMS - 1 odd-even sort phases over the cell row and result load. A restart
// word goes from accept to result load, an exhausted one from pivot search to it.
// One word is in work at a time; the output register holds a result while the
// next word is accepted, and the result load waits while the output is stalled.
// Reset loads the identity, a match count of one and an item count of eight.
`timescale 1ns / 1ps
`default_nettype none

module lex_permutation_fixed_point_counter (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // input words
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          restart_i,
  // result words
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [lpfc_pkg::PERM_W-1:0]  permutation_o,
  output logic                         has_fixed_point_o,
  output logic [lpfc_pkg::MATCH_W-1:0] match_count_o,
  output logic                         exhausted_o,
  // configuration
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [lpfc_pkg::CNT_W-1:0]   cfg_data_i
);
  import lpfc_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   item_count_q;
  logic [CNT_W-1:0]   n_act;
  logic [IDX_W-1:0]   piv_q, piv_d, succ_q, succ_d;
  logic [VAL_W-1:0]   piv_val_q, piv_val_d, succ_val_q, succ_val_d;
  logic [PH_W-1:0]    phase_q, phase_d;
  logic               inc_q, inc_d, exh_q, exh_d;
  logic [MATCH_W-1:0] count_q, count_d;
  logic               out_valid_q, out_valid_d;
  logic [PERM_W-1:0]  perm_q, perm_w;
  logic               fp_q, fp_w;
  logic [MATCH_W-1:0] match_q;
  logic               done_q;
  logic               load_out;

  logic [VAL_W-1:0]   vals  [MAX_ITEMS];
  logic [VAL_W-1:0]   packs [MAX_ITEMS];
  cell_flag_t         flags [MAX_ITEMS];
  cell_cmd_t          cmd;

  logic               found;
  logic [IDX_W-1:0]   rise_pos, gt_pos, rd_addr;
  logic [VAL_W-1:0]   rd_data;
  logic               in_acc;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // active length, clamped into one to the row size
  always_comb begin
    priority if (item_count_q == '0) begin
      n_act = CNT_W'(1);
    end else if (item_count_q > N_MAX) begin
      n_act = N_MAX;
    end else begin
      n_act = item_count_q;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= N_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      item_count_q <= cfg_data_i;
    end
  end

  // row of cells
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    logic [VAL_W-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = vals[k-1];
    end
    if (k == MAX_ITEMS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = vals[k+1];
    end
    lpfc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(k)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .val_o   (vals[k]),
      .pack_o  (packs[k]),
      .flag_o  (flags[k])
    );
  end

  // rightmost rise, rightmost greater successor, any fixed point and packed word
  always_comb begin
    found    = 1'b0;
    rise_pos = '0;
    gt_pos   = '0;
    fp_w     = 1'b0;
    perm_w   = '0;
    for (int k = 0; k < MAX_ITEMS; k++) begin
      if (flags[k].rise) begin
        found    = 1'b1;
        rise_pos = IDX_W'(k);
      end
      if (flags[k].gt) begin
        gt_pos = IDX_W'(k);
      end
      fp_w = fp_w | flags[k].fix;
      perm_w[k*VAL_W +: VAL_W] = packs[k];
    end
  end

  // single shared element read
  assign rd_addr = (state_q == ST_PIVOT) ? rise_pos : succ_q;
  assign rd_data = vals[rd_addr];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = restart_i ? ST_FINISH : ST_PIVOT;
        end
      end
      ST_PIVOT:  state_d = found ? ST_SUCC : ST_FINISH;
      ST_SUCC:   state_d = ST_SWAP;
      ST_SWAP:   state_d = ST_SORT;
      ST_SORT:   state_d = (phase_q == PH_LAST) ? ST_FINISH : ST_SORT;
      ST_FINISH: state_d = load_out ? ST_IDLE : ST_FINISH;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // sequencer outputs and datapath updates
  always_comb begin
    cmd.op       = OP_HOLD;
    cmd.par      = phase_q[0];
    cmd.n        = n_act;
    cmd.piv      = piv_q;
    cmd.succ     = succ_q;
    cmd.piv_val  = piv_val_q;
    cmd.succ_val = succ_val_q;
    piv_d        = piv_q;
    succ_d       = succ_q;
    piv_val_d    = piv_val_q;
    succ_val_d   = succ_val_q;
    phase_d      = phase_q;
    inc_d        = inc_q;
    exh_d        = exh_q;
    count_d      = count_q;
    in_stall_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        inc_d      = 1'b0;
        exh_d      = 1'b0;
        if (in_acc && restart_i) begin
          cmd.op  = OP_LOAD;
          count_d = MATCH_W'(1);
        end
      end
      ST_PIVOT: begin
        piv_d     = rise_pos;
        piv_val_d = rd_data;
        exh_d     = !found;
      end
      ST_SUCC: begin
        succ_d = gt_pos;
      end
      ST_SWAP: begin
        succ_val_d = rd_data;
        cmd.succ_val = rd_data;
        cmd.op     = OP_SWAP;
        phase_d    = '0;
      end
      ST_SORT: begin
        cmd.op  = OP_SORT;
        phase_d = phase_q + PH_W'(1);
        inc_d   = 1'b1;
      end
      ST_FINISH: begin
        if (load_out && inc_q && fp_w && (count_q != '1)) begin
          count_d = count_q + MATCH_W'(1);
        end
      end
      default: begin
        cmd.op = OP_HOLD;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      inc_q       <= 1'b0;
      exh_q       <= 1'b0;
      count_q     <= MATCH_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      inc_q       <= inc_d;
      exh_q       <= exh_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pivot and successor registers
  always_ff @(posedge clk_i) begin
    piv_q      <= piv_d;
    succ_q     <= succ_d;
    piv_val_q  <= piv_val_d;
    succ_val_q <= succ_val_d;
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      perm_q  <= perm_w;
      fp_q    <= fp_w;
      match_q <= count_d;
      done_q  <= exh_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign permutation_o     = perm_q;
  assign has_fixed_point_o = fp_q;
  assign match_count_o     = match_q;
  assign exhausted_o       = done_q;

endmodule : lex_permutation_fixed_point_counter

`default_nettype wire

>>> rtl/lpfc_cell.sv
// lpfc_cell: one element of the permutation row with neighbor compare-exchange
// depends on lpfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpfc_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire  [lpfc_pkg::IDX_W-1:0] idx_i,
  input  wire  lpfc_pkg::cell_cmd_t  cmd_i,
  input  wire  [lpfc_pkg::VAL_W-1:0] left_i,
  input  wire  [lpfc_pkg::VAL_W-1:0] right_i,
  output logic [lpfc_pkg::VAL_W-1:0] val_o,
  output logic [lpfc_pkg::VAL_W-1:0] pack_o,
  output lpfc_pkg::cell_flag_t     flag_o
);
  import lpfc_pkg::*;

  logic [VAL_W-1:0] val_q, val_d;
  logic [CNT_W-1:0] pos, pos_next, piv_w, piv_next;
  logic             active, right_active;
  logic             left_role, right_role;

  assign pos          = CNT_W'(idx_i);
  assign pos_next     = pos + CNT_W'(1);
  assign piv_w        = CNT_W'(cmd_i.piv);
  assign piv_next     = piv_w + CNT_W'(1);
  assign active       = pos < cmd_i.n;
  assign right_active = pos_next < cmd_i.n;

  // pair membership for this sort phase, only inside the suffix
  assign left_role  = (idx_i[0] == cmd_i.par) && (pos > piv_w) && right_active;
  assign right_role = (idx_i[0] != cmd_i.par) && (pos > piv_next) && active;

  // next element
  always_comb begin
    val_d = val_q;
    unique case (cmd_i.op)
      OP_HOLD: val_d = val_q;
      OP_LOAD: val_d = VAL_W'(idx_i);
      OP_SWAP: begin
        if (idx_i == cmd_i.piv) begin
          val_d = cmd_i.succ_val;
        end else if (idx_i == cmd_i.succ) begin
          val_d = cmd_i.piv_val;
        end
      end
      OP_SORT: begin
        if (left_role && (val_q > right_i)) begin
          val_d = right_i;
        end else if (right_role && (left_i > val_q)) begin
          val_d = left_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  // element register, reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= VAL_W'(idx_i);
    end else begin
      val_q <= val_d;
    end
  end

  // local status toward the sequencer
  always_comb begin
    flag_o.rise = right_active && (val_q < right_i);
    flag_o.gt   = active && (pos > piv_w) && (val_q > cmd_i.piv_val);
    flag_o.fix  = active && (val_q == VAL_W'(idx_i));
  end

  assign val_o  = val_q;
  assign pack_o = active ? val_q : '0;

endmodule : lpfc_cell

`default_nettype wire
